>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked while reset is low.
`define CSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, including during reset.
`define CSS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSS_ASSERT(label, clk, rst, prop, msg)
`define CSS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> sv/css420_pkg.sv
// ----------------------------------------------------------------------------
// Chroma subsampler package
// Widths, register indexes and types for the 4:4:4 to 4:2:0 converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package css420_pkg;

   localparam int PIX_W  = 8;
   localparam int PAIR_W = PIX_W + 1;
   localparam int CFG_W  = 13;
   localparam int CMP_W  = 14;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PAIR_W-1:0] cr;
      logic [PAIR_W-1:0] cb;
   } pair_sum_type;

endpackage

>>> sv/chroma_subsample_444_to_420.sv
// ----------------------------------------------------------------------------
// 4:4:4 to 4:2:0 chroma subsampler
// Passes luma through and box-averages chroma over each 2x2 pixel quad.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock unless stalled; each yields one
// registered result. A line store of MAX_WIDTH/2 entries, with one write
// and one registered read port, keeps the chroma pair sums of each even row;
// it needs no clearing after reset. A trailing odd column or row gives no
// chroma. Any write to a size register restarts the frame at its first pixel.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chroma_subsample_444_to_420
   import css420_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CFG_W-1:0]      csr_data,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_luma_in,
   input  logic [PIX_W-1:0]      req_cb_in,
   input  logic [PIX_W-1:0]      req_cr_in,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_luma_out,
   output logic                  rsp_chroma_valid,
   output logic [PIX_W-1:0]      rsp_cb_avg,
   output logic [PIX_W-1:0]      rsp_cr_avg,
   output logic                  rsp_frame_end
);

   localparam int XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic [CFG_W-1:0]  width_cfg_ff, height_cfg_ff;
   logic [CMP_W-1:0]  width_eff, height_eff;
   logic [XW-1:0]     col_ff, col_in;
   logic [YW-1:0]     row_ff, row_in;
   logic [CMP_W-1:0]  col_next, row_next;
   logic [PIX_W-1:0]  prev_cb_ff, prev_cr_ff;

   logic              accept;
   logic              cfg_write;
   logic              last_col;
   logic              frame_end;
   logic [AW-1:0]     slot;
   pair_sum_type      pair_sum;

   pair_sum_type      line_mem [LINE_DEPTH];
   pair_sum_type      line_rd_ff;

   logic              s1_valid_ff;
   logic [PIX_W-1:0]  s1_luma_ff;
   logic              s1_chroma_ff;
   logic              s1_fend_ff;
   pair_sum_type      s1_pair_ff;
   logic              s1_advance;

   logic [PAIR_W:0]   cb_sum, cr_sum;

   logic              rsp_valid_ff;
   logic [PIX_W-1:0]  rsp_luma_ff, rsp_cb_ff, rsp_cr_ff;
   logic              rsp_chroma_ff, rsp_fend_ff;

   function automatic logic [CMP_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CMP_W-1:0] max);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(v);
      if (v == '0) begin
         return CMP_W'(1);
      end else if (ext > max) begin
         return max;
      end
      return ext;
   endfunction

   assign csr_ready  = 1'b1;
   assign cfg_write  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= WIDTH_RESET;
         height_cfg_ff <= HEIGHT_RESET;
      end else if (cfg_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_cfg_ff  <= csr_data;
            CSR_FRAME_HEIGHT: height_cfg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign width_eff  = clamp_size(width_cfg_ff, CMP_W'(MAX_WIDTH));
   assign height_eff = clamp_size(height_cfg_ff, CMP_W'(MAX_HEIGHT));

   // Stage one moves on when the result register is empty or being drained.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign accept     = req_valid && !req_stall;

   assign col_next  = CMP_W'(col_ff) + CMP_W'(1);
   assign row_next  = CMP_W'(row_ff) + CMP_W'(1);
   assign last_col  = col_next >= width_eff;
   assign frame_end = last_col && (row_next >= height_eff);
   assign slot      = AW'(col_ff >> 1);

   assign pair_sum.cb = PAIR_W'(prev_cb_ff) + PAIR_W'(req_cb_in);
   assign pair_sum.cr = PAIR_W'(prev_cr_ff) + PAIR_W'(req_cr_in);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = (row_next >= height_eff) ? '0 : YW'(row_next);
         end else begin
            col_in = XW'(col_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_write) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_cb_ff <= '0;
         prev_cr_ff <= '0;
      end else if (accept) begin
         prev_cb_ff <= req_cb_in;
         prev_cr_ff <= req_cr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && col_ff[0] && !row_ff[0]) begin
         line_mem[slot] <= pair_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         line_rd_ff <= line_mem[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_luma_ff   <= req_luma_in;
         s1_chroma_ff <= col_ff[0] && row_ff[0];
         s1_fend_ff   <= frame_end;
         s1_pair_ff   <= pair_sum;
      end
   end

   assign cb_sum = (PAIR_W+1)'(line_rd_ff.cb) + (PAIR_W+1)'(s1_pair_ff.cb);
   assign cr_sum = (PAIR_W+1)'(line_rd_ff.cr) + (PAIR_W+1)'(s1_pair_ff.cr);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_luma_ff   <= s1_luma_ff;
         rsp_chroma_ff <= s1_chroma_ff;
         rsp_fend_ff   <= s1_fend_ff;
         rsp_cb_ff     <= s1_chroma_ff ? cb_sum[PAIR_W:2] : '0;
         rsp_cr_ff     <= s1_chroma_ff ? cr_sum[PAIR_W:2] : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_luma_out     = rsp_luma_ff;
   assign rsp_chroma_valid = rsp_chroma_ff;
   assign rsp_cb_avg       = rsp_cb_ff;
   assign rsp_cr_avg       = rsp_cr_ff;
   assign rsp_frame_end    = rsp_fend_ff;

   `CSS_ASSERT(a_stall_means_full, clock, reset, req_stall |-> (s1_valid_ff && rsp_valid_ff), "input stalled while a stage is free")
   `CSS_ASSERT(a_col_in_range, clock, reset, (CMP_W'(col_ff) < width_eff), "column counter beyond frame width")
   `CSS_ASSERT(a_row_in_range, clock, reset, (CMP_W'(row_ff) < height_eff), "row counter beyond frame height")
   `CSS_ASSERT(a_no_chroma_zero, clock, reset, (rsp_valid && !rsp_chroma_valid) |-> (rsp_cb_avg == '0 && rsp_cr_avg == '0), "chroma nonzero without a complete quad")
   `CSS_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (!s1_valid_ff && !rsp_valid_ff), "pipeline not empty after reset")

endmodule
